/* rtl/eam_pkg.sv */
// Shared types, constants and helper functions for the encoder angle mapper.
package eam_pkg;

    // Width of a wrapped intermediate value: product quotient plus headroom.
    localparam int QW = 48;
    localparam int WV = QW + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Conversion direction
    typedef enum logic {
        OP_E2R = 1'b0,  // encoder reading to position
        OP_R2E = 1'b1   // position to encoder reading
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROBOT_MAX   = 3'd0,
        CFG_ROBOT_MIN   = 3'd1,
        CFG_ENC_MAX     = 3'd2,
        CFG_ENC_MIN     = 3'd3,
        CFG_CAL_ROBOT   = 3'd4,
        CFG_CAL_ENCODER = 3'd5,
        CFG_SCALE_E2R   = 3'd6,
        CFG_SCALE_R2E   = 3'd7
    } t_cfg_idx;

    // Register reset values, Q16.16
    localparam logic signed [31:0] RST_ROBOT_MAX   = 32'sd11796480;
    localparam logic signed [31:0] RST_ROBOT_MIN   = -32'sd11796480;
    localparam logic signed [31:0] RST_ENC_MAX     = 32'sd327680;
    localparam logic signed [31:0] RST_ENC_MIN     = 32'sd0;
    localparam logic signed [31:0] RST_CAL_ROBOT   = 32'sd0;
    localparam logic signed [31:0] RST_CAL_ENCODER = 32'sd0;
    localparam logic signed [31:0] RST_SCALE_E2R   = 32'sd4718592;
    localparam logic signed [31:0] RST_SCALE_R2E   = 32'sd910;

    typedef struct packed {
        t_op                opcode;
        logic signed [31:0] value_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic               wrap_overflow;
    } t_out_beat;

    typedef struct packed {
        logic signed [31:0] robot_max;
        logic signed [31:0] robot_min;
        logic signed [31:0] enc_max;
        logic signed [31:0] enc_min;
        logic signed [31:0] cal_robot;
        logic signed [31:0] cal_encoder;
        logic signed [31:0] scale_e2r;
        logic signed [31:0] scale_r2e;
    } t_cfg;

    // Ordered bounds of one range and their span
    typedef struct packed {
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        logic        [32:0] span;
    } t_range;

    // Sign-extend a 32-bit value to the wrap width
    function automatic logic signed [WV-1:0] ext32(input logic signed [31:0] x);
        ext32 = {{(WV-32){x[31]}}, x};
    endfunction

    // Sign-extend a product quotient to the wrap width
    function automatic logic signed [WV-1:0] extq(input logic signed [QW-1:0] x);
        extq = {{(WV-QW){x[QW-1]}}, x};
    endfunction

    // Saturate a wide value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [WV-1:0] v);
        if (&v[WV-1:31] || ~|v[WV-1:31]) begin
            sat32 = v[31:0];
        end else if (v[WV-1]) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = 32'sh7fff_ffff;
        end
    endfunction

endpackage

/* rtl/encoder_angle_mapper_unit.sv */
// Top level of the encoder angle mapper: register file and conversion pipeline.
//
//  channel   direction  handshake                   payload
//  in        input      i_in_valid / o_in_ready     i_in_beat  (t_in_beat)
//  out       output     o_out_valid / i_out_ready   o_out_beat (t_out_beat)
//  cfg       input      i_cfg_wr_en                 i_cfg_idx, i_cfg_data
//
//  One beat per cycle sustained while the output is not stalled; the path
//  runs through the two wrap pipelines of 2*WRAP_PASSES+1 stages each plus
//  two three-stage arithmetic sections.
//  Synchronous active-low reset clears all valid bits and loads register defaults.
//  Each stage holds its beat while the next is full; empty stages keep filling
//  during an output stall, so no beat is dropped or repeated.
module encoder_angle_mapper_unit import eam_pkg::*; #(
    parameter int WRAP_PASSES = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_beat,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SIDE_W = $bits(t_op) + 32;

    t_cfg                 cfg;
    t_range               rob_rng;
    t_range               enc_rng;

    logic                 fr_valid, fr_ready;
    logic signed [WV-1:0] fr_off_raw;
    t_op                  fr_op;
    logic signed [31:0]   fr_x;

    logic                 ow_valid, ow_ready;
    logic signed [31:0]   ow_off;
    logic                 ow_ovf;
    logic [SIDE_W-1:0]    ow_side;

    logic                 sc_valid, sc_ready;
    logic signed [WV-1:0] sc_value;
    t_op                  sc_op;
    logic                 sc_ovf;

    logic signed [31:0]   rw_value;
    logic                 rw_ovf;

    // Configuration registers
    eam_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_rob       (rob_rng),
        .o_enc       (enc_rng)
    );

    // Capture, clamp, offset product
    eam_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_beat    (i_in_beat),
        .i_cfg     (cfg),
        .i_rob     (rob_rng),
        .i_enc     (enc_rng),
        .o_valid   (fr_valid),
        .i_ready   (fr_ready),
        .o_off_raw (fr_off_raw),
        .o_op      (fr_op),
        .o_x       (fr_x)
    );

    // Offset always wraps into the encoder range
    eam_wrap #(
        .PASSES (WRAP_PASSES),
        .SIDE_W (SIDE_W)
    ) u_off_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_value (fr_off_raw),
        .i_sel   (OP_R2E),
        .i_ovf   (1'b0),
        .i_side  ({fr_op, fr_x}),
        .i_rob   (rob_rng),
        .i_enc   (enc_rng),
        .o_valid (ow_valid),
        .i_ready (ow_ready),
        .o_value (ow_off),
        .o_ovf   (ow_ovf),
        .o_side  (ow_side)
    );

    // Scale and offset combine
    eam_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ow_valid),
        .o_ready (ow_ready),
        .i_off   (ow_off),
        .i_ovf   (ow_ovf),
        .i_op    (t_op'(ow_side[SIDE_W-1])),
        .i_x     (ow_side[31:0]),
        .i_cfg   (cfg),
        .o_valid (sc_valid),
        .i_ready (sc_ready),
        .o_value (sc_value),
        .o_op    (sc_op),
        .o_ovf   (sc_ovf)
    );

    // Result wraps into the target range of its direction
    eam_wrap #(
        .PASSES (WRAP_PASSES),
        .SIDE_W (1)
    ) u_res_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sc_valid),
        .o_ready (sc_ready),
        .i_value (sc_value),
        .i_sel   (sc_op),
        .i_ovf   (sc_ovf),
        .i_side  (1'b0),
        .i_rob   (rob_rng),
        .i_enc   (enc_rng),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_value (rw_value),
        .o_ovf   (rw_ovf),
        .o_side  ()
    );

    assign o_out_beat.value_out     = rw_value;
    assign o_out_beat.wrap_overflow = rw_ovf;

endmodule

/* rtl/eam_regs.sv */
// Configuration register file with registered ordered bounds and spans.
module eam_regs import eam_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output t_range                o_rob,
    output t_range                o_enc
);

    t_cfg   r_cfg;
    t_range r_rob;
    t_range r_enc;
    t_range n_rob;
    t_range n_enc;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.robot_max   <= RST_ROBOT_MAX;
            r_cfg.robot_min   <= RST_ROBOT_MIN;
            r_cfg.enc_max     <= RST_ENC_MAX;
            r_cfg.enc_min     <= RST_ENC_MIN;
            r_cfg.cal_robot   <= RST_CAL_ROBOT;
            r_cfg.cal_encoder <= RST_CAL_ENCODER;
            r_cfg.scale_e2r   <= RST_SCALE_E2R;
            r_cfg.scale_r2e   <= RST_SCALE_R2E;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ROBOT_MAX:   r_cfg.robot_max   <= i_cfg_data;
                CFG_ROBOT_MIN:   r_cfg.robot_min   <= i_cfg_data;
                CFG_ENC_MAX:     r_cfg.enc_max     <= i_cfg_data;
                CFG_ENC_MIN:     r_cfg.enc_min     <= i_cfg_data;
                CFG_CAL_ROBOT:   r_cfg.cal_robot   <= i_cfg_data;
                CFG_CAL_ENCODER: r_cfg.cal_encoder <= i_cfg_data;
                CFG_SCALE_E2R:   r_cfg.scale_e2r   <= i_cfg_data;
                CFG_SCALE_R2E:   r_cfg.scale_r2e   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Swap reversed bounds, derive span
    always_comb begin
        if (r_cfg.robot_max < r_cfg.robot_min) begin
            n_rob.hi = r_cfg.robot_min;
            n_rob.lo = r_cfg.robot_max;
        end else begin
            n_rob.hi = r_cfg.robot_max;
            n_rob.lo = r_cfg.robot_min;
        end
        n_rob.span = {n_rob.hi[31], n_rob.hi} - {n_rob.lo[31], n_rob.lo};

        if (r_cfg.enc_max < r_cfg.enc_min) begin
            n_enc.hi = r_cfg.enc_min;
            n_enc.lo = r_cfg.enc_max;
        end else begin
            n_enc.hi = r_cfg.enc_max;
            n_enc.lo = r_cfg.enc_min;
        end
        n_enc.span = {n_enc.hi[31], n_enc.hi} - {n_enc.lo[31], n_enc.lo};
    end

    // Derived ranges follow the registers in the next cycle
    always_ff @(posedge i_clk) begin
        r_rob <= n_rob;
        r_enc <= n_enc;
    end

    assign o_cfg = r_cfg;
    assign o_rob = r_rob;
    assign o_enc = r_enc;

endmodule

/* rtl/eam_wrap.sv */
// Wrap pipeline: conditional add stages, conditional subtract stages, saturate.
module eam_wrap import eam_pkg::*; #(
    parameter int PASSES = 2,
    parameter int SIDE_W = 33
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [WV-1:0]  i_value,
    input  t_op                   i_sel,
    input  logic                  i_ovf,
    input  logic [SIDE_W-1:0]     i_side,
    input  t_range                i_rob,
    input  t_range                i_enc,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [31:0]    o_value,
    output logic                  o_ovf,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int NST = 2 * PASSES + 1;

    logic [NST-1:0]         r_vld;
    logic signed [WV-1:0]   r_v    [NST];
    t_op                    r_sel  [NST];
    logic [NST-1:0]         r_ovf;
    logic [SIDE_W-1:0]      r_side [NST];
    logic [NST:0]           rdy;

    // Ready chain from the output back to the input
    assign rdy[NST] = i_ready;

    for (genvar k = 0; k < NST; k++) begin : g_stg
        logic                 s_vld;
        logic signed [WV-1:0] s_v;
        t_op                  s_sel;
        logic                 s_ovf;
        logic [SIDE_W-1:0]    s_side;
        t_range               rng;
        logic signed [WV-1:0] hi_w;
        logic signed [WV-1:0] lo_w;
        logic signed [WV-1:0] span_w;
        logic signed [WV-1:0] n_v;
        logic                 n_ovf;

        assign rdy[k] = !r_vld[k] || rdy[k+1];

        if (k == 0) begin : g_head
            assign s_vld  = i_valid;
            assign s_v    = i_value;
            assign s_sel  = i_sel;
            assign s_ovf  = i_ovf;
            assign s_side = i_side;
        end else begin : g_body
            assign s_vld  = r_vld[k-1];
            assign s_v    = r_v[k-1];
            assign s_sel  = r_sel[k-1];
            assign s_ovf  = r_ovf[k-1];
            assign s_side = r_side[k-1];
        end

        // Position wraps into the robot range, encoder into the encoder range
        always_comb begin
            rng    = (s_sel == OP_R2E) ? i_enc : i_rob;
            hi_w   = ext32(rng.hi);
            lo_w   = ext32(rng.lo);
            span_w = {{(WV-33){1'b0}}, rng.span};
            n_v    = s_v;
            n_ovf  = s_ovf;
            if (k < PASSES) begin
                if (s_v < lo_w) begin
                    n_v = s_v + span_w;
                end
            end else if (k < 2 * PASSES) begin
                if (s_v > hi_w) begin
                    n_v = s_v - span_w;
                end
            end else begin
                if (s_v < lo_w) begin
                    n_v   = lo_w;
                    n_ovf = 1'b1;
                end else if (s_v > hi_w) begin
                    n_v   = hi_w;
                    n_ovf = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k] && s_vld) begin
                r_v[k]    <= n_v;
                r_sel[k]  <= s_sel;
                r_ovf[k]  <= n_ovf;
                r_side[k] <= s_side;
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NST-1];
    assign o_value = r_v[NST-1][31:0];
    assign o_ovf   = r_ovf[NST-1];
    assign o_side  = r_side[NST-1];

endmodule

/* rtl/eam_front.sv */
// Front stages: capture, clamp plus offset product, raw offset difference.
module eam_front import eam_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_in_beat              i_beat,
    input  t_cfg                  i_cfg,
    input  t_range                i_rob,
    input  t_range                i_enc,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [WV-1:0]  o_off_raw,
    output t_op                   o_op,
    output logic signed [31:0]    o_x
);

    logic                 r_vld1, r_vld2, r_vld3;
    logic                 rdy1, rdy2, rdy3;
    t_op                  r_op1, r_op2, r_op3;
    logic signed [31:0]   r_x1, r_x2, r_x3;
    logic signed [31:0]   r_d1;
    logic signed [QW-1:0] r_q2;
    logic signed [WV-1:0] r_off3;

    logic signed [31:0]   n_d1;
    logic signed [31:0]   n_x2;
    logic signed [63:0]   prod2;
    t_range               rng2;
    logic signed [WV-1:0] n_off3;

    // Stage readiness
    assign rdy3    = !r_vld3 || i_ready;
    assign rdy2    = !r_vld2 || rdy3;
    assign rdy1    = !r_vld1 || rdy2;
    assign o_ready = rdy1;

    // Stage 1: saturated calibration distance from the position minimum
    assign n_d1 = sat32(ext32(i_cfg.cal_robot) - ext32(i_cfg.robot_min));

    // Stage 2: clamp to the source range, offset product
    always_comb begin
        rng2 = (r_op1 == OP_E2R) ? i_enc : i_rob;
        if (r_x1 > rng2.hi) begin
            n_x2 = rng2.hi;
        end else if (r_x1 < rng2.lo) begin
            n_x2 = rng2.lo;
        end else begin
            n_x2 = r_x1;
        end
        prod2 = r_d1 * i_cfg.scale_r2e;
    end

    // Stage 3: raw offset before wrap
    assign n_off3 = ext32(i_cfg.cal_encoder) - extq(r_q2);

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (rdy1) r_vld1 <= i_valid;
            if (rdy2) r_vld2 <= r_vld1;
            if (rdy3) r_vld3 <= r_vld2;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_op1 <= i_beat.opcode;
            r_x1  <= i_beat.value_in;
            r_d1  <= n_d1;
        end
        if (rdy2 && r_vld1) begin
            r_op2 <= r_op1;
            r_x2  <= n_x2;
            r_q2  <= prod2[63:16];
        end
        if (rdy3 && r_vld2) begin
            r_op3  <= r_op2;
            r_x3   <= r_x2;
            r_off3 <= n_off3;
        end
    end

    assign o_valid   = r_vld3;
    assign o_off_raw = r_off3;
    assign o_op      = r_op3;
    assign o_x       = r_x3;

endmodule

/* rtl/eam_scale.sv */
// Scale stages: operand select, product, offset add.
module eam_scale import eam_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [31:0]    i_off,
    input  logic                  i_ovf,
    input  t_op                   i_op,
    input  logic signed [31:0]    i_x,
    input  t_cfg                  i_cfg,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [WV-1:0]  o_value,
    output t_op                   o_op,
    output logic                  o_ovf
);

    logic                 r_vld1, r_vld2, r_vld3;
    logic                 rdy1, rdy2, rdy3;
    t_op                  r_op1, r_op2, r_op3;
    logic                 r_ovf1, r_ovf2, r_ovf3;
    logic signed [31:0]   r_off1, r_off2;
    logic signed [31:0]   r_a1, r_b1;
    logic signed [QW-1:0] r_q2;
    logic signed [WV-1:0] r_res3;

    logic signed [31:0]   n_a1;
    logic signed [31:0]   n_b1;
    logic signed [63:0]   prod2;
    logic signed [WV-1:0] n_res3;

    assign rdy3    = !r_vld3 || i_ready;
    assign rdy2    = !r_vld2 || rdy3;
    assign rdy1    = !r_vld1 || rdy2;
    assign o_ready = rdy1;

    // Stage 1: encoder minus offset for E2R, clamped position for R2E
    always_comb begin
        if (i_op == OP_E2R) begin
            n_a1 = sat32(ext32(i_x) - ext32(i_off));
            n_b1 = i_cfg.scale_e2r;
        end else begin
            n_a1 = i_x;
            n_b1 = i_cfg.scale_r2e;
        end
    end

    // Stage 2: Q16.16 product, arithmetic shift floors toward minus infinity
    assign prod2 = r_a1 * r_b1;

    // Stage 3: R2E adds the offset back
    assign n_res3 = (r_op2 == OP_E2R) ? extq(r_q2) : ext32(r_off2) + extq(r_q2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (rdy1) r_vld1 <= i_valid;
            if (rdy2) r_vld2 <= r_vld1;
            if (rdy3) r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_op1  <= i_op;
            r_ovf1 <= i_ovf;
            r_off1 <= i_off;
            r_a1   <= n_a1;
            r_b1   <= n_b1;
        end
        if (rdy2 && r_vld1) begin
            r_op2  <= r_op1;
            r_ovf2 <= r_ovf1;
            r_off2 <= r_off1;
            r_q2   <= prod2[63:16];
        end
        if (rdy3 && r_vld2) begin
            r_op3  <= r_op2;
            r_ovf3 <= r_ovf2;
            r_res3 <= n_res3;
        end
    end

    assign o_valid = r_vld3;
    assign o_value = r_res3;
    assign o_op    = r_op3;
    assign o_ovf   = r_ovf3;

endmodule
